// ===== hdl/ppef_pkg.sv =====
`timescale 1ns / 1ps

package ppef_pkg;

	localparam int PHASE_BITS    = 18;
	localparam int CORDIC_STAGES = 18;
	localparam int NUM_ST        = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

	// CORDIC vector width and angle accumulator width
	localparam int VW       = 26;
	localparam int ZW       = PHASE_BITS + 2;
	// magnitude bits of pos - low
	localparam int DIV_BITS = 33;
	localparam int AXIS_LAT = DIV_BITS + 8 + PHASE_BITS + 2 * NUM_ST;

	localparam logic [16:0] ALPHA_ONE = 17'd65536;
	localparam logic signed [VW-1:0] VEC_START = VW'(1 << 20);

	typedef enum logic [2:0] {
		REG_ALPHA   = 3'd0,
		REG_X_LOW   = 3'd1,
		REG_X_SPAN  = 3'd2,
		REG_Y_LOW   = 3'd3,
		REG_Y_SPAN  = 3'd4,
		REG_Z_LOW   = 3'd5,
		REG_Z_SPAN  = 3'd6,
		REG_PASS    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] low;
		logic [30:0]        span;
		logic [16:0]        wa;
		logic [16:0]        wb;
	} axis_cfg_t;

	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// atan(2^-i) as a phase fraction, rounded half up
	function automatic logic signed [ZW-1:0] step_angle(int i);
		logic [32:0] t;
		t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (31 - PHASE_BITS));
		return ZW'(t >> (32 - PHASE_BITS));
	endfunction

endpackage

// ===== hdl/ppef_axis.sv =====
`timescale 1ns / 1ps

module ppef_axis (
	input  logic                      clk,
	input  logic                      en,
	input  ppef_pkg::axis_cfg_t       cfg,
	input  logic signed [31:0]        raw,
	input  logic signed [31:0]        prev,
	output logic [31:0]               filt
);

	localparam int P   = ppef_pkg::PHASE_BITS;
	localparam int NST = ppef_pkg::NUM_ST;
	localparam int VW  = ppef_pkg::VW;
	localparam int ZW  = ppef_pkg::ZW;
	localparam int DB  = ppef_pkg::DIV_BITS;

	// operand 0 is raw, operand 1 is prev
	logic [DB-1:0]          md_dv_s  [2][DB+1];
	logic [30:0]            md_rem_s [2][DB+1];
	logic                   md_neg_s [2][DB+1];
	logic [30:0]            fr_rem_s [2][P+1];
	logic [P-1:0]           fr_ph_s  [2][P+1];
	logic signed [VW-1:0]   rx_s     [2][NST+1];
	logic signed [VW-1:0]   ry_s     [2][NST+1];
	logic signed [ZW-1:0]   rz_s     [2][NST+1];
	logic                   rflip_s  [2][NST+1];
	logic signed [VW+17:0]  pc_s     [2];
	logic signed [VW+17:0]  ps_s     [2];
	logic signed [VW-1:0]   bx_s;
	logic signed [VW-1:0]   by_s;
	logic                   bz_s;
	logic signed [VW-1:0]   vx_s     [NST+1];
	logic signed [VW-1:0]   vy_s     [NST+1];
	logic signed [ZW-1:0]   vz_s     [NST+1];
	logic                   vzero_s  [NST+1];
	logic [P+30:0]          prod_s;
	logic                   pzero_s;
	logic [31:0]            filt_s;

	logic signed [31:0]     pos [2];
	assign pos[0] = raw;
	assign pos[1] = prev;

	genvar j, k;
	generate
		for (j = 0; j < 2; j++) begin : g_op
			logic signed [32:0] d;
			assign d = 33'(pos[j]) - 33'(cfg.low);

			always_ff @(posedge clk) begin
				if (en) begin
					md_neg_s[j][0] <= d[32];
					md_dv_s[j][0]  <= d[32] ? DB'(-d) : DB'(d);
					md_rem_s[j][0] <= '0;
				end
			end

			// restoring remainder of |pos - low| by span, one dividend bit a stage
			for (k = 0; k < DB; k++) begin : g_mod
				logic [31:0] t;
				logic        ge;
				assign t  = {md_rem_s[j][k], md_dv_s[j][k][DB-1]};
				assign ge = t >= {1'b0, cfg.span};
				always_ff @(posedge clk) begin
					if (en) begin
						md_rem_s[j][k+1] <= ge ? 31'(t - {1'b0, cfg.span}) : t[30:0];
						md_dv_s[j][k+1]  <= {md_dv_s[j][k][DB-2:0], 1'b0};
						md_neg_s[j][k+1] <= md_neg_s[j][k];
					end
				end
			end

			// floor modulo: fold a negative remainder back into [0, span)
			always_ff @(posedge clk) begin
				if (en) begin
					fr_rem_s[j][0] <= (md_neg_s[j][DB] && md_rem_s[j][DB] != '0)
						? (cfg.span - md_rem_s[j][DB]) : md_rem_s[j][DB];
					fr_ph_s[j][0]  <= '0;
				end
			end

			// phase = r * 2^P / span, one fraction bit a stage
			for (k = 0; k < P; k++) begin : g_frac
				logic [31:0] t;
				logic        ge;
				assign t  = {fr_rem_s[j][k], 1'b0};
				assign ge = t >= {1'b0, cfg.span};
				always_ff @(posedge clk) begin
					if (en) begin
						fr_rem_s[j][k+1] <= ge ? 31'(t - {1'b0, cfg.span}) : t[30:0];
						fr_ph_s[j][k+1]  <= {fr_ph_s[j][k][P-2:0], ge};
					end
				end
			end

			// reduce the phase to [-quarter, quarter]
			logic signed [ZW-1:0] z0;
			logic signed [ZW-1:0] quarter;
			logic signed [ZW-1:0] half;
			assign z0      = ZW'($signed(fr_ph_s[j][P]));
			assign quarter = ZW'(1 << (P - 2));
			assign half    = ZW'(1 << (P - 1));

			always_ff @(posedge clk) begin
				if (en) begin
					rx_s[j][0] <= ppef_pkg::VEC_START;
					ry_s[j][0] <= '0;
					if (z0 > quarter) begin
						rz_s[j][0]    <= z0 - half;
						rflip_s[j][0] <= 1'b1;
					end else if (z0 < -quarter) begin
						rz_s[j][0]    <= z0 + half;
						rflip_s[j][0] <= 1'b1;
					end else begin
						rz_s[j][0]    <= z0;
						rflip_s[j][0] <= 1'b0;
					end
				end
			end

			for (k = 0; k < NST; k++) begin : g_rot
				always_ff @(posedge clk) begin
					if (en) begin
						rflip_s[j][k+1] <= rflip_s[j][k];
						if (rz_s[j][k] >= 0) begin
							rx_s[j][k+1] <= rx_s[j][k] - (ry_s[j][k] >>> k);
							ry_s[j][k+1] <= ry_s[j][k] + (rx_s[j][k] >>> k);
							rz_s[j][k+1] <= rz_s[j][k] - ppef_pkg::step_angle(k);
						end else begin
							rx_s[j][k+1] <= rx_s[j][k] + (ry_s[j][k] >>> k);
							ry_s[j][k+1] <= ry_s[j][k] - (rx_s[j][k] >>> k);
							rz_s[j][k+1] <= rz_s[j][k] + ppef_pkg::step_angle(k);
						end
					end
				end
			end

			logic signed [VW-1:0] cv, sv;
			logic signed [17:0]   w;
			assign cv = rflip_s[j][NST] ? -rx_s[j][NST] : rx_s[j][NST];
			assign sv = rflip_s[j][NST] ? -ry_s[j][NST] : ry_s[j][NST];
			assign w  = (j == 0) ? $signed({1'b0, cfg.wa}) : $signed({1'b0, cfg.wb});

			always_ff @(posedge clk) begin
				if (en) begin
					pc_s[j] <= w * cv;
					ps_s[j] <= w * sv;
				end
			end
		end
	endgenerate

	logic signed [VW+18:0] sum_c, sum_s;
	logic signed [VW-1:0]  bx, by;
	assign sum_c = (VW+19)'(pc_s[0]) + (VW+19)'(pc_s[1]);
	assign sum_s = (VW+19)'(ps_s[0]) + (VW+19)'(ps_s[1]);
	assign bx    = VW'(sum_c >>> 16);
	assign by    = VW'(sum_s >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s <= bx;
			by_s <= by;
			bz_s <= (bx == '0) && (by == '0);
		end
	end

	// move the blend into the right half plane before vectoring
	always_ff @(posedge clk) begin
		if (en) begin
			vzero_s[0] <= bz_s;
			if (bx_s < 0) begin
				vx_s[0] <= -bx_s;
				vy_s[0] <= -by_s;
				vz_s[0] <= ZW'(1 << (P - 1));
			end else begin
				vx_s[0] <= bx_s;
				vy_s[0] <= by_s;
				vz_s[0] <= '0;
			end
		end
	end

	generate
		for (k = 0; k < NST; k++) begin : g_vec
			always_ff @(posedge clk) begin
				if (en) begin
					vzero_s[k+1] <= vzero_s[k];
					if (vy_s[k] < 0) begin
						vx_s[k+1] <= vx_s[k] - (vy_s[k] >>> k);
						vy_s[k+1] <= vy_s[k] + (vx_s[k] >>> k);
						vz_s[k+1] <= vz_s[k] - ppef_pkg::step_angle(k);
					end else begin
						vx_s[k+1] <= vx_s[k] + (vy_s[k] >>> k);
						vy_s[k+1] <= vy_s[k] - (vx_s[k] >>> k);
						vz_s[k+1] <= vz_s[k] + ppef_pkg::step_angle(k);
					end
				end
			end
		end
	endgenerate

	logic [P-1:0] ang;
	assign ang = vz_s[NST][P-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s  <= (P+31)'(ang) * (P+31)'(cfg.span);
			pzero_s <= vzero_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pzero_s || cfg.span == '0)
				filt_s <= cfg.low;
			else
				filt_s <= cfg.low + {1'b0, prod_s[P+30:P]};
		end
	end

	assign filt = filt_s;

endmodule

// ===== hdl/periodic_position_ema_filter_core.sv =====
`timescale 1ns / 1ps

// Circular exponential moving average of a particle position in a periodic box.
// Input channel (in_valid / in_stall) carries raw_x/y/z and prev_x/y/z; a
// transaction completes on a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall) carries filt_x/y/z the same way.
// Configuration is written over cfg_valid / cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while the block is empty.
// Each axis pipeline is built from a 33 stage remainder pipe, a phase-bits
// stage fraction divider, two CORDIC chains of CORDIC_STAGES each and a few
// blend and scale stages.
// Throughput is one transaction per cycle while out_stall does not hold the output.
// When the output is held by out_stall the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and loads alpha 655, lows 0, spans 1.0 and
// pass_through set, so results copy the raw position until it is cleared.

module periodic_position_ema_filter_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] raw_x,
	input  logic signed [31:0] raw_y,
	input  logic signed [31:0] raw_z,
	input  logic signed [31:0] prev_x,
	input  logic signed [31:0] prev_y,
	input  logic signed [31:0] prev_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] filt_x,
	output logic signed [31:0] filt_y,
	output logic signed [31:0] filt_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LAT = ppef_pkg::AXIS_LAT;

	logic [16:0]        alpha_q;
	logic signed [31:0] x_low_q, y_low_q, z_low_q;
	logic [30:0]        x_span_q, y_span_q, z_span_q;
	logic               pass_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 17'd655;
			x_low_q  <= '0;
			y_low_q  <= '0;
			z_low_q  <= '0;
			x_span_q <= 31'd65536;
			y_span_q <= 31'd65536;
			z_span_q <= 31'd65536;
			pass_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (ppef_pkg::reg_idx_t'(cfg_index))
				ppef_pkg::REG_ALPHA:  alpha_q  <= cfg_data[16:0];
				ppef_pkg::REG_X_LOW:  x_low_q  <= cfg_data;
				ppef_pkg::REG_X_SPAN: x_span_q <= cfg_data[30:0];
				ppef_pkg::REG_Y_LOW:  y_low_q  <= cfg_data;
				ppef_pkg::REG_Y_SPAN: y_span_q <= cfg_data[30:0];
				ppef_pkg::REG_Z_LOW:  z_low_q  <= cfg_data;
				ppef_pkg::REG_Z_SPAN: z_span_q <= cfg_data[30:0];
				ppef_pkg::REG_PASS:   pass_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp alpha to one
	logic [16:0] wa, wb;
	assign wa = (alpha_q > ppef_pkg::ALPHA_ONE) ? ppef_pkg::ALPHA_ONE : alpha_q;
	assign wb = ppef_pkg::ALPHA_ONE - wa;

	ppef_pkg::axis_cfg_t cfg_x, cfg_y, cfg_z;
	assign cfg_x = '{low: x_low_q, span: x_span_q, wa: wa, wb: wb};
	assign cfg_y = '{low: y_low_q, span: y_span_q, wa: wa, wb: wb};
	assign cfg_z = '{low: z_low_q, span: z_span_q, wa: wa, wb: wb};

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [LAT:1]       vld_s;
	logic [31:0]        dly_x_s [1:LAT];
	logic [31:0]        dly_y_s [1:LAT];
	logic [31:0]        dly_z_s [1:LAT];
	logic [31:0]        ax_x, ax_y, ax_z;
	logic               out_valid_q;
	logic [31:0]        fx_q, fy_q, fz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[LAT-1:1], in_valid};
	end

	// carry the raw position alongside for pass through
	always_ff @(posedge clk) begin
		if (en) begin
			dly_x_s[1] <= raw_x;
			dly_y_s[1] <= raw_y;
			dly_z_s[1] <= raw_z;
			for (int i = 2; i <= LAT; i++) begin
				dly_x_s[i] <= dly_x_s[i-1];
				dly_y_s[i] <= dly_y_s[i-1];
				dly_z_s[i] <= dly_z_s[i-1];
			end
		end
	end

	ppef_axis u_axis_x (.clk(clk), .en(en), .cfg(cfg_x), .raw(raw_x), .prev(prev_x), .filt(ax_x));
	ppef_axis u_axis_y (.clk(clk), .en(en), .cfg(cfg_y), .raw(raw_y), .prev(prev_y), .filt(ax_y));
	ppef_axis u_axis_z (.clk(clk), .en(en), .cfg(cfg_z), .raw(raw_z), .prev(prev_z), .filt(ax_z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vld_s[LAT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_q <= pass_q ? dly_x_s[LAT] : ax_x;
			fy_q <= pass_q ? dly_y_s[LAT] : ax_y;
			fz_q <= pass_q ? dly_z_s[LAT] : ax_z;
		end
	end

	assign out_valid = out_valid_q;
	assign filt_x    = fx_q;
	assign filt_y    = fy_q;
	assign filt_z    = fz_q;

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_s))
		else $error("pipeline valid bits moved during a stall");

	a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input accepted while output is held");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAT] && !in_stall) |=> out_valid)
		else $error("transaction dropped at the output register");

endmodule

// ===== bench/periodic_position_ema_filter_core_tb.sv =====
`timescale 1ns / 1ps

module periodic_position_ema_filter_core_tb;

	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] raw_x, raw_y, raw_z;
	logic signed [31:0] prev_x, prev_y, prev_z;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] filt_x, filt_y, filt_z;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	logic [31:0] cfg_shadow [8];
	pos_t        filt_q [$];
	int          errors;
	int          idle_cycles;
	int          stall_hold;

	periodic_position_ema_filter_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] reg_mask(ppef_pkg::reg_idx_t idx);
		case (idx)
			ppef_pkg::REG_ALPHA: return 32'h0001FFFF;
			ppef_pkg::REG_X_SPAN, ppef_pkg::REG_Y_SPAN, ppef_pkg::REG_Z_SPAN:
				return 32'h7FFFFFFF;
			ppef_pkg::REG_PASS: return 32'h1;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	// ---------------- predictor ----------------
	function automatic longint turn_step(int i);
		return (longint'(ppef_pkg::ATAN_TURN32[i])
			+ (longint'(1) << (31 - ppef_pkg::PHASE_BITS)))
			>>> (32 - ppef_pkg::PHASE_BITS);
	endfunction

	function automatic longint pos_phase(logic [31:0] pos, longint low, longint span);
		longint d, r;
		d = longint'($signed(pos)) - low;
		r = d % span;
		if (r < 0) r += span;
		return (r << ppef_pkg::PHASE_BITS) / span;
	endfunction

	function automatic void phase_to_vec(longint ph, output longint cx, output longint sy);
		longint fullt, half, quarter, z, x, y, xs, ys;
		bit flip;
		fullt = longint'(1) << ppef_pkg::PHASE_BITS;
		half = fullt >>> 1;
		quarter = fullt >>> 2;
		z = ph;
		x = longint'(1) << 20;
		y = 0;
		flip = 0;
		if (z >= half) z -= fullt;
		if (z > quarter) begin
			z -= half;
			flip = 1;
		end else if (z < -quarter) begin
			z += half;
			flip = 1;
		end
		for (int i = 0; i < ppef_pkg::CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= turn_step(i);
			end else begin
				x += ys; y -= xs; z += turn_step(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cx = x;
		sy = y;
	endfunction

	function automatic longint vec_to_phase(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = longint'(1) << (ppef_pkg::PHASE_BITS - 1);
		end
		for (int i = 0; i < ppef_pkg::CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x -= ys; y += xs; z -= turn_step(i);
			end else begin
				x += ys; y -= xs; z += turn_step(i);
			end
		end
		return z & ((longint'(1) << ppef_pkg::PHASE_BITS) - 1);
	endfunction

	function automatic logic [31:0] smooth_axis(logic [31:0] raw, logic [31:0] prev,
			logic [31:0] low_r, logic [31:0] span_r);
		longint low, span, wa, wb, cr, sr, cp, sp, bx, by, ang;
		low = longint'($signed(low_r));
		span = longint'(span_r);
		if (span == 0) return low_r;
		wa = (cfg_shadow[ppef_pkg::REG_ALPHA] > 32'd65536) ? 65536
			: longint'(cfg_shadow[ppef_pkg::REG_ALPHA]);
		wb = 65536 - wa;
		phase_to_vec(pos_phase(raw, low, span), cr, sr);
		phase_to_vec(pos_phase(prev, low, span), cp, sp);
		bx = (wa * cr + wb * cp) >>> 16;
		by = (wa * sr + wb * sp) >>> 16;
		if (bx == 0 && by == 0) return low_r;
		ang = vec_to_phase(bx, by);
		return 32'(low + ((ang * span) >>> ppef_pkg::PHASE_BITS));
	endfunction

	function automatic pos_t predict_filt(pos_t raw, pos_t prev);
		pos_t r;
		if (cfg_shadow[ppef_pkg::REG_PASS][0]) return raw;
		r.x = smooth_axis(raw.x, prev.x, cfg_shadow[ppef_pkg::REG_X_LOW],
			cfg_shadow[ppef_pkg::REG_X_SPAN]);
		r.y = smooth_axis(raw.y, prev.y, cfg_shadow[ppef_pkg::REG_Y_LOW],
			cfg_shadow[ppef_pkg::REG_Y_SPAN]);
		r.z = smooth_axis(raw.z, prev.z, cfg_shadow[ppef_pkg::REG_Z_LOW],
			cfg_shadow[ppef_pkg::REG_Z_SPAN]);
		return r;
	endfunction

	// ---------------- drivers ----------------
	task automatic send_pos(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		pos_t raw, prev;
		int gap;
		raw = '{rx, ry, rz};
		prev = '{px, py, pz};
		in_valid <= 1'b1;
		raw_x <= rx; raw_y <= ry; raw_z <= rz;
		prev_x <= px; prev_y <= py; prev_z <= pz;
		do @(posedge clk); while (in_stall);
		filt_q.push_back(predict_filt(raw, prev));
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (filt_q.size() != 0) @(posedge clk);
		repeat (ppef_pkg::AXIS_LAT + 8) @(posedge clk);
	endtask

	task automatic cfg_write(ppef_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_shadow[idx] = val & reg_mask(idx);
	endtask

	task automatic apply_cfg(logic [31:0] alpha, logic [31:0] xl, logic [31:0] xs,
			logic [31:0] yl, logic [31:0] ys, logic [31:0] zl, logic [31:0] zs,
			logic [31:0] pass);
		wait_idle();
		cfg_write(ppef_pkg::REG_ALPHA, alpha);
		cfg_write(ppef_pkg::REG_X_LOW, xl);
		cfg_write(ppef_pkg::REG_X_SPAN, xs);
		cfg_write(ppef_pkg::REG_Y_LOW, yl);
		cfg_write(ppef_pkg::REG_Y_SPAN, ys);
		cfg_write(ppef_pkg::REG_Z_LOW, zl);
		cfg_write(ppef_pkg::REG_Z_SPAN, zs);
		cfg_write(ppef_pkg::REG_PASS, pass);
		cfg_valid <= 1'b0;
	endtask

	// mostly prev near raw, as a real trajectory; the rest unrelated positions
	task automatic send_random_pos();
		logic [31:0] rx, ry, rz;
		rx = $urandom; ry = $urandom; rz = $urandom;
		if ($urandom_range(0, 9) < 7)
			send_pos(rx, ry, rz,
				rx + $signed(32'($urandom_range(0, 131072)) - 32'd65536),
				ry + $signed(32'($urandom_range(0, 131072)) - 32'd65536),
				rz + $signed(32'($urandom_range(0, 131072)) - 32'd65536));
		else
			send_pos(rx, ry, rz, $urandom, $urandom, $urandom);
	endtask

	// ---------------- tests ----------------
	task automatic test_pass_through();
		send_pos(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h12345678, 32'h0, 32'hFFFFFFFF);
		send_pos(32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h0);
		repeat (20) send_random_pos();
		apply_cfg(32'd655, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h1);
		repeat (10) send_random_pos();
	endtask

	task automatic test_extremes();
		apply_cfg(32'd655, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h0);
		send_pos(32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 32'h80000000);
		send_pos(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1);
		send_pos(32'h4000, 32'h8000, 32'hC000, 32'hC000, 32'h8000, 32'h4000);
		// opposite points with equal weight: the blend vanishes
		apply_cfg(32'd32768, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h0, 32'd65536, 32'h0);
		send_pos(32'h0, 32'h4000, 32'h2000, 32'h8000, 32'hC000, 32'hA000);
		send_pos(32'h10000, 32'h0, 32'h0, 32'h18000, 32'h0, 32'h8000);
		// alpha of zero, one and above one
		apply_cfg(32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h1, 32'h0, 32'h0, 32'h0);
		send_pos(32'h12345678, 32'h80000000, 32'h1, 32'h87654321, 32'h7FFFFFFF, 32'h2);
		send_pos(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h5, 32'h80000000, 32'h0, 32'h6);
		apply_cfg(32'd65536, 32'h7FFF0000, 32'h7FFFFFFF, 32'h80000000, 32'h30000,
			32'hFFFF0000, 32'h20000, 32'h0);
		send_pos(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0);
		send_pos(32'h12345678, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h12345678, 32'h1);
		apply_cfg(32'h1FFFF, 32'h7FFFFFFF, 32'h40000000, 32'h0, 32'h0, 32'h80000000,
			32'hFFFFFFFF, 32'h0);
		send_pos(32'h80000000, 32'h11111111, 32'h7FFFFFFF, 32'h0, 32'h22222222, 32'h80000000);
		send_pos(32'hDEADBEEF, 32'h0, 32'h0, 32'h0, 32'hDEADBEEF, 32'h7FFFFFFF);
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 6; ph++) begin
			logic [31:0] span_sel [3];
			for (int k = 0; k < 3; k++)
				case ($urandom_range(0, 4))
					0: span_sel[k] = 32'($urandom_range(1, 16)) << 16;
					1: span_sel[k] = $urandom_range(1, 3);
					2: span_sel[k] = 32'h7FFFFFFF;
					default: span_sel[k] = $urandom;
				endcase
			apply_cfg((ph == 0) ? 32'd0 : (ph == 1) ? 32'd65536 : $urandom,
				$urandom, span_sel[0], $urandom, span_sel[1], $urandom, span_sel[2],
				(ph == 5) ? 32'h1 : 32'h0);
			repeat (125) send_random_pos();
		end
	endtask

	// ---------------- checking ----------------
	always @(posedge clk) begin
		pos_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (filt_q.size() == 0) begin
				$error("unexpected output transaction x=%h y=%h z=%h", filt_x, filt_y, filt_z);
				errors++;
			end else begin
				e = filt_q.pop_front();
				if (filt_x !== e.x) begin
					$error("filt_x: expected %h actual %h", e.x, filt_x);
					errors++;
				end
				if (filt_y !== e.y) begin
					$error("filt_y: expected %h actual %h", e.y, filt_y);
					errors++;
				end
				if (filt_z !== e.z) begin
					$error("filt_z: expected %h actual %h", e.z, filt_z);
					errors++;
				end
			end
		end
	end

	// random back-pressure on the output side
	initial begin
		int n;
		out_stall = 1'b0;
		stall_hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_hold > 0) begin
				out_stall <= 1'b1;
				stall_hold--;
			end else begin
				n = pick_gap();
				out_stall <= (n > 0);
				stall_hold = (n > 0) ? n - 1 : 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("periodic_position_ema_filter_core_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_x = '0; raw_y = '0; raw_z = '0;
		prev_x = '0; prev_y = '0; prev_z = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		cfg_shadow = '{32'd655, 32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0, 32'd65536, 32'd1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pass_through();
		test_extremes();
		test_random_settings();
		wait_idle();
		if (errors == 0)
			$display("periodic_position_ema_filter_core_tb: PASS");
		else
			$display("periodic_position_ema_filter_core_tb: FAIL");
		$finish;
	end

endmodule
